/* design/wat_pkg.sv */
package wat_pkg;

   localparam int unsigned DAY_W = 17;
   localparam int unsigned DUE_W = 32;
   localparam int unsigned DAYS_PER_WEEK = 7;
   localparam logic [DAY_W-1:0] DAY_LENGTH_RESET = 17'd86400;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      REG_DAY_LENGTH = 1'b0,
      REG_SUN_LOW = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic        operation;
      logic [2:0]  slot;
      logic        entry_valid_in;
      logic [7:0]  alarm_id;
      logic        alarm_action;
      logic [6:0]  weekday_mask;
      logic [31:0] due_time;
      logic [31:0] now_second;
      logic [2:0]  now_weekday;
   } req_type;

   typedef struct packed {
      logic [7:0] fired_id;
      logic       fired_action;
      logic       kept;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_MUL,
      ST_EMIT
   } back_state_type;

   // Status passed from the back part to the front part.
   typedef struct packed {
      logic ready;
      logic done;
   } back_status_type;

   // Distance in days (1..7) to the next marked day, 0 for an empty mask.
   function automatic logic [2:0] days_ahead(input logic [6:0] mask_raw,
                                             input logic sun_low,
                                             input logic [2:0] weekday);
      logic [6:0] mask;
      logic [2:0] wd;
      logic [2:0] today;
      logic [2:0] idx;
      logic [3:0] sum;
      logic [2:0] result;
      mask = sun_low ? {mask_raw[0], mask_raw[6:1]} : mask_raw;
      wd = (weekday == 3'd7) ? 3'd0 : weekday;
      today = (wd == 3'd0) ? 3'd6 : wd - 3'd1;
      result = 3'd0;
      for (int d = 7; d >= 1; d--) begin
         sum = {1'b0, today} + 4'(d);
         idx = (sum >= 4'(DAYS_PER_WEEK)) ? 3'(sum - 4'(DAYS_PER_WEEK)) : sum[2:0];
         if (mask[idx]) begin
            result = 3'(d);
         end
      end
      return result;
   endfunction

endpackage

/* design/wat_front.sv */
module wat_front import wat_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_item,
   input  back_status_type status,
   output logic            q_valid,
   output req_type         q_item
);

   // Two-entry queue of accepted transactions; front stops while it is full or while a taken tick is unfinished.
   req_type    q_ff [2];
   req_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       pending_ff, pending_in;
   logic       pop;

   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = q_ff[0];
   assign pop     = q_valid && status.ready;
   // One tick is processed at a time, so a new start waits for the back part.
   assign busy    = (cnt_ff == 2'd2) || pending_ff;

   always_comb begin
      logic [1:0] c;
      q_in = q_ff;
      c = cnt_ff;
      pending_in = pending_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         c = c - 2'd1;
         pending_in = 1'b1;
      end
      if (status.done) begin
         pending_in = 1'b0;
      end
      if (start && !busy) begin
         q_in[c[0]] = req_item;
         c = c + 2'd1;
      end
      cnt_in = c;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
         pending_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         pending_ff <= pending_in;
      end
   end

endmodule

/* design/wat_back.sv */
module wat_back import wat_pkg::*; #(
   parameter int unsigned ENTRIES = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  req_type         q_item,
   input  logic [DAY_W-1:0] day_length,
   input  logic            sun_low,
   output back_status_type status,
   output logic            rsp_valid,
   output rsp_type         rsp_item
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] fired_ff, fired_in;
   logic [7:0]         id_mem [ENTRIES];
   logic               act_mem [ENTRIES];
   logic [6:0]         mask_mem [ENTRIES];
   logic [DUE_W-1:0]   due_mem [ENTRIES];

   back_state_type state_ff, state_in;
   req_type        cur_ff;
   logic [IW:0]    scan_ff, scan_in;
   logic           found_ff, found_in;
   logic [IW-1:0]  best_ff, best_in;
   logic [DUE_W-1:0] best_due_ff, best_due_in;
   logic [2:0]     days_ff;
   logic [DUE_W-1:0] sum_ff;
   logic           take;
   logic           slot_ok;
   logic [IW-1:0]  sidx;
   logic           cand;

   assign take = (state_ff == ST_IDLE) && q_valid;
   assign slot_ok = ({29'd0, q_item.slot} < 32'(ENTRIES));
   assign sidx = scan_ff[IW-1:0];
   assign cand = (scan_ff < (IW+1)'(ENTRIES)) && valid_ff[sidx] && !fired_ff[sidx]
                 && (due_mem[sidx] <= cur_ff.now_second);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take && q_item.operation == OP_TICK) state_in = ST_SCAN;
         ST_SCAN: if (scan_ff == (IW+1)'(ENTRIES)) state_in = ST_PICK;
         ST_PICK: state_in = found_ff ? ST_MUL : ST_IDLE;
         ST_MUL:  state_in = ST_EMIT;
         ST_EMIT: state_in = ST_SCAN;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      fired_in = fired_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_due_in = best_due_ff;
      status.ready = (state_ff == ST_IDLE);
      status.done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            found_in = 1'b0;
            fired_in = '0;
            if (take) begin
               if (q_item.operation == OP_LOAD) begin
                  status.done = 1'b1;
                  if (slot_ok) begin
                     valid_in[IW'(q_item.slot)] = q_item.entry_valid_in;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff != (IW+1)'(ENTRIES)) begin
               if (cand && (!found_ff || due_mem[sidx] < best_due_ff)) begin
                  found_in = 1'b1;
                  best_in = sidx;
                  best_due_in = due_mem[sidx];
               end
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_PICK: begin
            if (!found_ff) status.done = 1'b1;
         end
         ST_MUL: begin
            fired_in[best_ff] = 1'b1;
            if (days_ff == 3'd0) valid_in[best_ff] = 1'b0;
         end
         ST_EMIT: begin
            scan_in = '0;
            found_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) cur_ff <= q_item;
      if (take && q_item.operation == OP_LOAD && q_item.entry_valid_in && slot_ok) begin
         id_mem[IW'(q_item.slot)] <= q_item.alarm_id;
         act_mem[IW'(q_item.slot)] <= q_item.alarm_action;
         mask_mem[IW'(q_item.slot)] <= q_item.weekday_mask;
         due_mem[IW'(q_item.slot)] <= q_item.due_time;
      end
      if (state_ff == ST_PICK) begin
         days_ff <= days_ahead(mask_mem[best_ff], sun_low, cur_ff.now_weekday);
      end
      if (state_ff == ST_MUL) begin
         sum_ff <= cur_ff.now_second + DUE_W'({days_ff, 17'd0} >> 17) * DUE_W'(day_length);
      end
      if (state_ff == ST_EMIT && days_ff != 3'd0) begin
         due_mem[best_ff] <= sum_ff;
      end
      best_ff <= best_in;
      best_due_ff <= best_due_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         fired_ff <= '0;
         scan_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         fired_ff <= fired_in;
         scan_ff <= scan_in;
         found_ff <= found_in;
      end
   end

   // A fired alarm is held back one scan so that its last flag is known.
   logic    hold_ff, hold_in;
   rsp_type held_ff, held_in;

   always_comb begin
      hold_in = hold_ff;
      held_in = held_ff;
      rsp_valid = 1'b0;
      rsp_item = held_ff;
      if (state_ff == ST_EMIT) begin
         rsp_valid = hold_ff;
         rsp_item.last = 1'b0;
         hold_in = 1'b1;
         held_in.fired_id = id_mem[best_ff];
         held_in.fired_action = act_mem[best_ff];
         held_in.kept = (days_ff != 3'd0);
         held_in.last = 1'b0;
      end else if (state_ff == ST_PICK && !found_ff && hold_ff) begin
         rsp_valid = 1'b1;
         rsp_item.last = 1'b1;
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) hold_ff <= 1'b0;
      else       hold_ff <= hold_in;
   end

endmodule

/* design/weekly_alarm_table.sv */
// Order: a load takes effect once the back part takes it from the queue; a tick gives
// its results one by one from a serial scan, as each result waits one scan for its last flag.
// Throughput: one load per cycle; a tick keeps busy high until it is finished.
// Reset (synchronous, active high) empties the table, sets day_length to 86400 and clears the
// Sunday-bit option. The receiver cannot stall: each result is shown for exactly one cycle.
module weekly_alarm_table import wat_pkg::*; #(
   parameter int unsigned ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [DAY_W-1:0] day_length_ff;
   logic             sun_low_ff;
   logic             q_valid;
   req_type          q_item;
   back_status_type  status;
   logic             wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         day_length_ff <= DAY_LENGTH_RESET;
         sun_low_ff <= 1'b0;
      end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_DAY_LENGTH) begin
         day_length_ff <= pwdata[DAY_W-1:0];
      end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_SUN_LOW) begin
         sun_low_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_DAY_LENGTH) prdata = {15'd0, day_length_ff};
      else prdata = {31'd0, sun_low_ff};
   end

   wat_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .status(status), .q_valid(q_valid), .q_item(q_item)
   );

   wat_back #(.ENTRIES(ENTRIES)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .day_length(day_length_ff), .sun_low(sun_low_ff), .status(status),
      .rsp_valid(rsp_strobe), .rsp_item(rsp_item)
   );

   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |=> !rsp_strobe)
      else $error("result follows a last result directly");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || q_valid)
      else $error("accepted transaction vanished");
   a_kept_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_item.kept))
      else $error("kept flag unknown");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import wat_pkg::*;

   localparam int unsigned SLOTS = 8;
   // Longest tick in the back part plus a margin: the quiet time before a register write.
   localparam int unsigned SETTLE_CYCLES = SLOTS * (SLOTS + 4) + 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Model of the alarm table and its registers.
   logic             alarm_valid [SLOTS];
   logic [7:0]       alarm_id_q [SLOTS];
   logic             alarm_action_q [SLOTS];
   logic [6:0]       alarm_mask [SLOTS];
   logic [31:0]      alarm_due [SLOTS];
   logic [DAY_W-1:0] day_seconds = DAY_LENGTH_RESET;
   logic             sun_low = 1'b0;

   rsp_type     fired_alarms [$];
   int          error_count = 0;
   logic [31:0] clock_now = '0;

   weekly_alarm_table #(.ENTRIES(SLOTS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int unsigned days_to_next(input logic [6:0] raw, input logic [2:0] wd);
      logic [6:0] m;
      int unsigned today;
      m = sun_low ? {raw[0], raw[6:1]} : raw;
      today = ((wd % 7) + 6) % 7;
      for (int d = 1; d <= 7; d++) begin
         if (m[(today + d) % 7]) return d;
      end
      return 0;
   endfunction

   // Works out the alarms that one accepted transaction fires and updates the table.
   task automatic fire_due_alarms(input req_type r);
      logic        done [SLOTS];
      int          pick;
      int unsigned days;
      rsp_type     res;
      int          first_idx;
      if (r.operation == OP_LOAD) begin
         alarm_valid[r.slot] = r.entry_valid_in;
         if (r.entry_valid_in) begin
            alarm_id_q[r.slot] = r.alarm_id;
            alarm_action_q[r.slot] = r.alarm_action;
            alarm_mask[r.slot] = r.weekday_mask;
            alarm_due[r.slot] = r.due_time;
         end
         return;
      end
      first_idx = fired_alarms.size();
      foreach (done[i]) done[i] = 1'b0;
      forever begin
         pick = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (alarm_valid[i] && !done[i] && alarm_due[i] <= r.now_second &&
                (pick < 0 || alarm_due[i] < alarm_due[pick])) pick = i;
         end
         if (pick < 0) break;
         done[pick] = 1'b1;
         days = days_to_next(alarm_mask[pick], r.now_weekday);
         res.fired_id = alarm_id_q[pick];
         res.fired_action = alarm_action_q[pick];
         res.kept = (days != 0);
         res.last = 1'b0;
         if (days == 0) alarm_valid[pick] = 1'b0;
         else alarm_due[pick] = r.now_second + 32'(days * day_seconds);
         fired_alarms.push_back(res);
      end
      if (fired_alarms.size() > first_idx) fired_alarms[$].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (fired_alarms.size() == 0) begin
            report_mismatch($sformatf("unexpected alarm id %0d", rsp_item.fired_id));
         end else begin
            rsp_type want;
            want = fired_alarms.pop_front();
            if (rsp_item.fired_id !== want.fired_id)
               report_mismatch($sformatf("fired_id %0d, want %0d",
                                         rsp_item.fired_id, want.fired_id));
            if (rsp_item.fired_action !== want.fired_action)
               report_mismatch($sformatf("fired_action of id %0d", want.fired_id));
            if (rsp_item.kept !== want.kept)
               report_mismatch($sformatf("kept of id %0d", want.fired_id));
            if (rsp_item.last !== want.last)
               report_mismatch($sformatf("last of id %0d", want.fired_id));
         end
      end
   end

   // Sends one transaction; with idling on, start is sometimes dropped for a random burst afterwards.
   task automatic send_item(input req_type r, input bit idling);
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      fire_due_alarms(r);
      if (idling && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_load(input logic [2:0] s, input logic v, input logic [7:0] id,
                            input logic act, input logic [6:0] m, input logic [31:0] due,
                            input bit idling);
      req_type r;
      r = req_type'({$urandom, $urandom});
      r.operation = OP_LOAD;
      r.slot = s;
      r.entry_valid_in = v;
      r.alarm_id = id;
      r.alarm_action = act;
      r.weekday_mask = m;
      r.due_time = due;
      send_item(r, idling);
   endtask

   task automatic send_tick(input logic [31:0] now, input logic [2:0] wd, input bit idling);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom});
      r.operation = OP_TICK;
      r.now_second = now;
      r.now_weekday = wd;
      send_item(r, idling);
   endtask

   task automatic wait_quiet;
      start <= 1'b0;
      @(posedge clock);
      while (fired_alarms.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_DAY_LENGTH) day_seconds = value[DAY_W-1:0];
      else sun_low = value[0];
   endtask

   task automatic test_directed;
      send_load(3'd0, 1'b1, 8'd0, 1'b0, 7'h00, 32'd0, 1'b0);
      send_load(3'd1, 1'b1, 8'd255, 1'b1, 7'h7F, 32'd10, 1'b0);
      send_load(3'd2, 1'b1, 8'd2, 1'b1, 7'h40, 32'd10, 1'b0);
      send_load(3'd3, 1'b1, 8'd3, 1'b0, 7'h01, 32'd5, 1'b0);
      send_load(3'd4, 1'b1, 8'd4, 1'b1, 7'h2A, 32'hFFFF_FFFF, 1'b0);
      send_load(3'd5, 1'b1, 8'd5, 1'b0, 7'h55, 32'd20, 1'b0);
      send_load(3'd6, 1'b1, 8'd6, 1'b1, 7'h00, 32'd12, 1'b0);
      send_load(3'd7, 1'b1, 8'd7, 1'b1, 7'h08, 32'd11, 1'b0);
      // Emptying slot five leaves its contents but it must no longer fire.
      send_load(3'd5, 1'b0, 8'd99, 1'b1, 7'h7F, 32'd0, 1'b0);
      send_tick(32'd3, 3'd1, 1'b0);
      send_tick(32'd12, 3'd0, 1'b0);
      send_tick(32'd12, 3'd6, 1'b0);
      send_tick(32'hFFFF_FFFF, 3'd7, 1'b0);
      send_tick(32'hFFFF_FFFF, 3'd3, 1'b0);
      wait_quiet();
   endtask

   task automatic test_register_settings;
      write_reg(REG_DAY_LENGTH, 32'd0);
      write_reg(REG_SUN_LOW, 32'd1);
      // With a zero day length a repeating alarm falls due again at the same second.
      send_load(3'd0, 1'b1, 8'hA5, 1'b1, 7'h01, 32'd100, 1'b0);
      send_load(3'd1, 1'b1, 8'h5A, 1'b0, 7'h40, 32'd100, 1'b0);
      send_tick(32'd100, 3'd2, 1'b0);
      send_tick(32'd100, 3'd5, 1'b0);
      wait_quiet();
      write_reg(REG_DAY_LENGTH, 32'h1FFFF);
      send_tick(32'hFFFF_FF00, 3'd4, 1'b0);
      wait_quiet();
      write_reg(REG_DAY_LENGTH, 32'd1);
      write_reg(REG_SUN_LOW, 32'd0);
      send_tick(32'hFFFF_FFFF, 3'd0, 1'b0);
      wait_quiet();
   endtask

   task automatic random_phase(input int count, input bit idling);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) == 0) begin
            // Noise: fully random content.
            if ($urandom_range(0, 1))
               send_load(3'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                         7'($urandom), $urandom, idling);
            else
               send_tick($urandom, 3'($urandom), idling);
            n++;
         end else begin
            // A few loads near the current second, then ticks that move time forward.
            repeat ($urandom_range(1, 4)) begin
               send_load(3'($urandom), $urandom_range(0, 5) != 0, 8'($urandom),
                         1'($urandom), $urandom_range(0, 3) == 0 ? 7'h00 : 7'($urandom),
                         clock_now + $urandom_range(0, 40), idling);
               n++;
            end
            repeat ($urandom_range(1, 3)) begin
               clock_now += $urandom_range(0, 30);
               send_tick(clock_now, 3'($urandom), idling);
               n++;
            end
         end
      end
      wait_quiet();
   endtask

   task automatic test_random;
      clock_now = 32'hFFFF_F000;
      write_reg(REG_DAY_LENGTH, 32'd7);
      random_phase(80, 1'b1);
      write_reg(REG_SUN_LOW, 32'd1);
      write_reg(REG_DAY_LENGTH, 32'd3);
      random_phase(80, 1'b1);
      write_reg(REG_DAY_LENGTH, 32'd86400);
      random_phase(60, 1'b1);
      write_reg(REG_SUN_LOW, 32'd0);
      write_reg(REG_DAY_LENGTH, 32'd1);
      random_phase(60, 1'b1);
      write_reg(REG_DAY_LENGTH, 32'd11);
      random_phase(70, 1'b0);
   endtask

   initial begin
      foreach (alarm_valid[i]) alarm_valid[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_settings();
      test_random();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
